// ----- rtl/core/ipgm_pkg.sv -----
// Shared constants, types and helpers for the inverse perspective ground map.
package ipgm_pkg;
   localparam int COORD_WIDTH = 12;
   localparam int FRAC_BITS   = 16;
   localparam int WORD_WIDTH  = 32;
   localparam int DIV_WIDTH   = WORD_WIDTH + FRAC_BITS;
   localparam int DIV_TAG_W   = 2 + 3 * WORD_WIDTH;
   localparam int CSR_WIDTH   = 64;
   localparam int CSR_IDX_W   = 3;

   localparam logic [2:0] REG_P0_P2   = 3'd0;
   localparam logic [2:0] REG_P3_P4   = 3'd1;
   localparam logic [2:0] REG_P6_P7   = 3'd2;
   localparam logic [2:0] REG_P8_P10  = 3'd3;
   localparam logic [2:0] REG_P11_R0  = 3'd4;
   localparam logic [2:0] REG_R2_R3   = 3'd5;
   localparam logic [2:0] REG_MAXD    = 3'd6;
   localparam logic [2:0] REG_ROWS    = 3'd7;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ABOVE = 2'd1;
   localparam logic [1:0] ST_DEPTH = 2'd2;
   localparam logic [1:0] ST_ZERO  = 2'd3;

   localparam logic [30:0] MAXD_RESET = 31'(30 << FRAC_BITS);
   localparam logic [11:0] ROWS_RESET = 12'd480;

   typedef logic signed [WORD_WIDTH-1:0] word_type;

   function automatic word_type sat_word(input logic signed [66:0] a);
      if (a > 67'sd2147483647) return 32'sh7fffffff;
      if (a < -67'sd2147483648) return 32'sh80000000;
      return a[31:0];
   endfunction
endpackage

// ----- rtl/core/ipgm_divider.sv -----
// Pipelined signed divider for fixed-point quotients, one quotient bit per stage.
module ipgm_divider
   import ipgm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  word_type                    in_num,
   input  word_type                    in_den,
   input  logic [DIV_TAG_W-1:0]        in_tag,
   output logic                        out_valid,
   output word_type                    out_quo,
   output logic [DIV_TAG_W-1:0]        out_tag
);
   localparam int N = DIV_WIDTH;
   logic [N:0]           vld_ff;
   logic [N-1:0]         rem_ff [N+1];
   logic [N-1:0]         quo_ff [N+1];
   logic [WORD_WIDTH-1:0] dv_ff [N+1];
   logic [N:0]           neg_ff;
   logic [DIV_TAG_W-1:0] tag_ff [N+1];
   logic [N-1:0]         anum;
   logic [WORD_WIDTH-1:0] aden;
   logic signed [N:0]    qs;

   always_comb begin
      anum = in_num[WORD_WIDTH-1] ? N'(-{{FRAC_BITS{in_num[31]}}, in_num}) : N'(in_num);
      anum = N'(anum << FRAC_BITS);
      aden = in_den[WORD_WIDTH-1] ? WORD_WIDTH'(-in_den) : WORD_WIDTH'(in_den);
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[N-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= '0;
         quo_ff[0] <= anum;
         dv_ff[0]  <= aden;
         neg_ff[0] <= in_num[31] ^ in_den[31];
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_st
      logic [N:0] trial_in;
      logic [N:0] diff;
      assign trial_in = {rem_ff[i], quo_ff[i][N-1]};
      assign diff = trial_in - {{(N+1-WORD_WIDTH){1'b0}}, dv_ff[i]};
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i+1] <= diff[N] ? trial_in[N-1:0] : diff[N-1:0];
            quo_ff[i+1] <= {quo_ff[i][N-2:0], ~diff[N]};
            dv_ff[i+1]  <= dv_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            tag_ff[i+1] <= tag_ff[i];
         end
      end
   end

   always_comb begin
      qs = neg_ff[N] ? -$signed({1'b0, quo_ff[N]}) : $signed({1'b0, quo_ff[N]});
      out_quo = sat_word(67'(qs));
   end
   assign out_valid = vld_ff[N];
   assign out_tag = tag_ff[N];
endmodule

// ----- rtl/core/inverse_perspective_ground_map.sv -----
// Top level of the inverse perspective ground map.
// Each req_ word carries one pixel (column, row); each rsp_ word returns
// the flat-ground X and Z in signed Q15.16 with a status code.
// One pixel can be accepted every clock unless a stall on rsp_ holds
// the chain. The pipeline is a single chain: coefficient products, two
// parallel 49-stage dividers (input stage plus 48 quotient bit stages)
// for the two c1 quotients, products and sums, a third 49-stage divider
// for Z, then the X term and the depth check. The restoring dividers
// resolve one quotient bit per stage. A stall on a valid rsp_ word
// freezes the whole chain; req_stall follows it, so no word is lost
// or repeated. Synchronous reset clears all valid bits and sets the
// registers to their reset values (coefficients zero, depth limit
// 30.0, image height 480). Configuration is written through csr_; the
// user must do so only while no pixel is in flight (not enforced).
module inverse_perspective_ground_map
   import ipgm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [COORD_WIDTH-1:0]    req_pixel_col,
   input  logic [COORD_WIDTH-1:0]    req_pixel_row,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [31:0]        rsp_ground_x,
   output logic signed [31:0]        rsp_ground_z,
   output logic [1:0]                rsp_map_status,
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_WIDTH-1:0]      csr_data
);
   logic [CSR_WIDTH-1:0] r_ff [6];
   logic [30:0] maxd_ff;
   logic [11:0] rows_ff;
   logic adv;
   assign adv = ~(rsp_valid & rsp_stall);
   assign req_stall = ~adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) r_ff[i] <= '0;
         maxd_ff <= MAXD_RESET;
         rows_ff <= ROWS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_P0_P2, REG_P3_P4, REG_P6_P7, REG_P8_P10, REG_P11_R0, REG_R2_R3:
               r_ff[csr_index] <= csr_data;
            REG_MAXD: maxd_ff <= csr_data[30:0];
            REG_ROWS: rows_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   word_type p0, p2, p3, p4, p6, p7, p8, p10, p11, r0, r2, r3;
   assign p0 = r_ff[0][31:0];  assign p2  = r_ff[0][63:32];
   assign p3 = r_ff[1][31:0];  assign p4  = r_ff[1][63:32];
   assign p6 = r_ff[2][31:0];  assign p7  = r_ff[2][63:32];
   assign p8 = r_ff[3][31:0];  assign p10 = r_ff[3][63:32];
   assign p11 = r_ff[4][31:0]; assign r0  = r_ff[4][63:32];
   assign r2 = r_ff[5][31:0];  assign r3  = r_ff[5][63:32];

   // Stage 1: the six c terms, with midline test.
   logic s1_v_ff;
   word_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   logic s1_above_ff;
   logic signed [COORD_WIDTH:0] su, sv;
   assign su = $signed({1'b0, req_pixel_col});
   assign sv = $signed({1'b0, req_pixel_row});

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (adv) s1_v_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_above_ff <= {1'b0, req_pixel_row} < {2'b0, rows_ff[11:1]};
         c1_ff <= sat_word(67'(p0) - 67'(45'(p8) * 45'(su)));
         c2_ff <= sat_word(67'(p4) - 67'(45'(p8) * 45'(sv)));
         c3_ff <= sat_word(67'(45'(p11) * 45'(sv)) - 67'(p7));
         c4_ff <= sat_word(67'(p6) - 67'(45'(p10) * 45'(sv)));
         c5_ff <= sat_word(67'(p2) - 67'(45'(p10) * 45'(su)));
         c6_ff <= sat_word(67'(45'(p11) * 45'(su)) - 67'(p3));
      end
   end

   // Dividers for q5 and q6 carry the other terms as tag.
   localparam int T1 = 2 + 3 * WORD_WIDTH;
   logic [T1-1:0] t1_in, t1_out;
   logic q5_v, q6_v;
   word_type q5, q6;
   logic [T1-1:0] t1b_unused;
   assign t1_in = {s1_above_ff, c1_ff == 0, c2_ff, c3_ff, c4_ff};
   ipgm_divider u_div5 (
      .clock, .reset, .advance(adv), .in_valid(s1_v_ff), .in_num(c5_ff),
      .in_den(c1_ff), .in_tag(t1_in), .out_valid(q5_v), .out_quo(q5), .out_tag(t1_out));
   ipgm_divider u_div6 (
      .clock, .reset, .advance(adv), .in_valid(s1_v_ff), .in_num(c6_ff),
      .in_den(c1_ff), .in_tag(t1_in), .out_valid(q6_v), .out_quo(q6), .out_tag(t1b_unused));

   // Stage products q6*c2 and q5*c2.
   logic s2_v_ff, s2_above_ff, s2_z1_ff;
   logic signed [63:0] m6_ff, m5_ff;
   word_type s2_c3_ff, s2_c4_ff, s2_q5_ff, s2_q6_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (adv) s2_v_ff <= q5_v & q6_v;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         {s2_above_ff, s2_z1_ff} <= t1_out[T1-1:T1-2];
         m6_ff <= q6 * $signed(t1_out[95:64]);
         m5_ff <= q5 * $signed(t1_out[95:64]);
         s2_c3_ff <= t1_out[63:32];
         s2_c4_ff <= t1_out[31:0];
         s2_q5_ff <= q5;
         s2_q6_ff <= q6;
      end
   end

   logic s3_v_ff, s3_above_ff, s3_z1_ff;
   word_type num_ff, den_ff, s3_q5_ff, s3_q6_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (adv) s3_v_ff <= s2_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_above_ff <= s2_above_ff;
         s3_z1_ff <= s2_z1_ff;
         num_ff <= sat_word(67'(s2_c3_ff) - 67'(m6_ff >>> FRAC_BITS));
         den_ff <= sat_word(67'(s2_c4_ff) - 67'(m5_ff >>> FRAC_BITS));
         s3_q5_ff <= s2_q5_ff;
         s3_q6_ff <= s2_q6_ff;
      end
   end

   localparam int T2 = 3 + 2 * WORD_WIDTH;
   logic [DIV_TAG_W-1:0] t2_out;
   logic zq_v;
   word_type zq;
   ipgm_divider u_divz (
      .clock, .reset, .advance(adv), .in_valid(s3_v_ff), .in_num(num_ff), .in_den(den_ff),
      .in_tag(DIV_TAG_W'({s3_above_ff, s3_z1_ff, den_ff == 0, s3_q5_ff, s3_q6_ff})),
      .out_valid(zq_v), .out_quo(zq), .out_tag(t2_out));

   logic s4_v_ff;
   logic [2:0] s4_fl_ff;
   logic signed [63:0] m5z_ff, m2z_ff;
   word_type s4_q6_ff, s4_z_ff;
   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else if (adv) s4_v_ff <= zq_v;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_fl_ff <= t2_out[T2-1:T2-3];
         m5z_ff <= $signed(t2_out[63:32]) * zq;
         m2z_ff <= r2 * zq;
         s4_q6_ff <= t2_out[31:0];
         s4_z_ff <= zq;
      end
   end

   logic s5_v_ff;
   logic [2:0] s5_fl_ff;
   word_type s5_x_ff, s5_z_ff;
   logic signed [48:0] s5_part_ff;
   word_type x5;
   assign x5 = sat_word(67'(s4_q6_ff) - 67'(m5z_ff >>> FRAC_BITS));
   always_ff @(posedge clock) begin
      if (reset) s5_v_ff <= 1'b0;
      else if (adv) s5_v_ff <= s4_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s5_fl_ff <= s4_fl_ff;
         s5_x_ff <= x5;
         s5_z_ff <= s4_z_ff;
         s5_part_ff <= 49'(m2z_ff >>> FRAC_BITS) + 49'(r3);
      end
   end

   logic s6_v_ff;
   logic [2:0] s6_fl_ff;
   word_type s6_x_ff, s6_z_ff;
   logic signed [63:0] m0x_ff;
   logic signed [48:0] s6_part_ff;
   always_ff @(posedge clock) begin
      if (reset) s6_v_ff <= 1'b0;
      else if (adv) s6_v_ff <= s5_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s6_fl_ff <= s5_fl_ff;
         s6_x_ff <= s5_x_ff;
         s6_z_ff <= s5_z_ff;
         m0x_ff <= r0 * s5_x_ff;
         s6_part_ff <= s5_part_ff;
      end
   end

   logic signed [49:0] depth;
   logic [1:0] st;
   assign depth = 50'(m0x_ff >>> FRAC_BITS) + 50'(s6_part_ff);
   always_comb begin
      if (s6_fl_ff[2]) st = ST_ABOVE;
      else if (s6_fl_ff[1] | s6_fl_ff[0]) st = ST_ZERO;
      else if (depth > $signed({19'b0, maxd_ff})) st = ST_DEPTH;
      else st = ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= s6_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_map_status <= st;
         rsp_ground_x <= (st == ST_OK) ? s6_x_ff : '0;
         rsp_ground_z <= (st == ST_OK) ? s6_z_ff : '0;
      end
   end
endmodule

// ----- rtl/core/ipgm_checker.sv -----
// Port-level checks for the inverse perspective ground map, bound to the top level.
module ipgm_checker
   import ipgm_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic signed [31:0] rsp_ground_x,
   input logic signed [31:0] rsp_ground_z,
   input logic [1:0] rsp_map_status
);
   a_zero_x: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_map_status != ST_OK |-> rsp_ground_x == 0 && rsp_ground_z == 0)
      else $error("nonzero coordinate with error status");
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output stall");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ground_x))
      else $error("stalled word changed");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("valid after reset");
endmodule

bind inverse_perspective_ground_map ipgm_checker u_ipgm_checker (.*);

// ----- tb/sv/inverse_perspective_ground_map_test.sv -----
// Testbench for the inverse perspective ground map: random pixels checked against a predictor.
module inverse_perspective_ground_map_test;
   import ipgm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] z;
      logic [1:0]         status;
   } ground_point_type;

   class ground_scoreboard_type;
      logic [63:0] regs [8];
      ground_point_type pending [$];
      int errors;

      function new();
         foreach (regs[i]) regs[i] = '0;
         regs[REG_MAXD] = 64'(MAXD_RESET);
         regs[REG_ROWS] = 64'(ROWS_RESET);
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] data);
         if (idx == REG_MAXD) data &= 64'h7fffffff;
         if (idx == REG_ROWS) data &= 64'hfff;
         regs[idx] = data;
      endfunction

      function longint lo(logic [63:0] w);
         return longint'($signed(w[31:0]));
      endfunction

      function longint hi(logic [63:0] w);
         return longint'($signed(w[63:32]));
      endfunction

      function longint clamp(longint a);
         if (a > 64'sd2147483647) return 64'sd2147483647;
         if (a < -64'sd2147483648) return -64'sd2147483648;
         return a;
      endfunction

      function longint fmul(longint a, longint b);
         return (a * b) >>> FRAC_BITS;
      endfunction

      function longint fdiv(longint a, longint b);
         return clamp((a <<< FRAC_BITS) / b);
      endfunction

      function void note_pixel(logic [11:0] col, logic [11:0] row);
         longint u, v, c1, c2, c3, c4, c5, c6, q5, q6, num, den, z, x, depth;
         ground_point_type p;
         u = longint'(col);
         v = longint'(row);
         p.x = 0;
         p.z = 0;
         p.status = ST_OK;
         if (v < longint'(regs[REG_ROWS] >> 1)) begin
            p.status = ST_ABOVE;
         end else begin
            c1 = clamp(lo(regs[0]) - lo(regs[3]) * u);
            c2 = clamp(hi(regs[1]) - lo(regs[3]) * v);
            c3 = clamp(lo(regs[4]) * v - hi(regs[2]));
            c4 = clamp(lo(regs[2]) - hi(regs[3]) * v);
            c5 = clamp(hi(regs[0]) - hi(regs[3]) * u);
            c6 = clamp(lo(regs[4]) * u - lo(regs[1]));
            if (c1 == 0) begin
               p.status = ST_ZERO;
            end else begin
               q5 = fdiv(c5, c1);
               q6 = fdiv(c6, c1);
               num = clamp(c3 - fmul(q6, c2));
               den = clamp(c4 - fmul(q5, c2));
               if (den == 0) begin
                  p.status = ST_ZERO;
               end else begin
                  z = fdiv(num, den);
                  x = clamp(q6 - fmul(q5, z));
                  depth = fmul(hi(regs[4]), x) + fmul(lo(regs[5]), z) + hi(regs[5]);
                  if (depth > longint'(regs[REG_MAXD])) begin
                     p.status = ST_DEPTH;
                  end else begin
                     p.x = x[31:0];
                     p.z = z[31:0];
                  end
               end
            end
         end
         pending.push_back(p);
      endfunction

      function void check_point(logic signed [31:0] x, logic signed [31:0] z,
                                logic [1:0] status);
         ground_point_type e;
         if (pending.size() == 0) begin
            $error("rsp word with no expected result");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (x !== e.x) begin
            $error("ground_x expected %0d actual %0d", e.x, x);
            errors++;
         end
         if (z !== e.z) begin
            $error("ground_z expected %0d actual %0d", e.z, z);
            errors++;
         end
         if (status !== e.status) begin
            $error("map_status expected %0d actual %0d", e.status, status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [COORD_WIDTH-1:0] req_pixel_col = '0;
   logic [COORD_WIDTH-1:0] req_pixel_row = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_ground_x;
   logic signed [31:0] rsp_ground_z;
   logic [1:0] rsp_map_status;
   logic csr_write = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0] csr_data = '0;
   logic calm = 0;

   ground_scoreboard_type board = new();

   inverse_perspective_ground_map dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #50ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver stalls in random bursts.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 5);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_point(rsp_ground_x, rsp_ground_z, rsp_map_status);
   end

   task automatic write_csr(logic [2:0] idx, logic [63:0] data);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= data;
      board.write_reg(idx, data);
      @(posedge clock);
      csr_write <= 0;
   endtask

   task automatic send_pixel(logic [11:0] col, logic [11:0] row);
      int n;
      if (!calm && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 5);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_pixel_col <= col;
      req_pixel_row <= row;
      do @(posedge clock); while (req_stall);
      board.note_pixel(col, row);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [31:0] coef();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      endcase
   endfunction

   // A plausible camera: c1 varies with u, den with v.
   task automatic load_camera(bit wild);
      write_csr(REG_P0_P2, {coef(), wild ? coef() : 32'h00010000});
      write_csr(REG_P3_P4, {coef(), coef()});
      write_csr(REG_P6_P7, {coef(), coef()});
      write_csr(REG_P8_P10, {coef(), wild ? coef() : 32'h00000100});
      write_csr(REG_P11_R0, {coef(), coef()});
      write_csr(REG_R2_R3, {coef(), coef()});
      write_csr(REG_MAXD, $urandom_range(0, 3) == 0 ? 64'h7fffffff : 64'($urandom));
      write_csr(REG_ROWS, $urandom_range(0, 3) == 0 ? 64'(0) : 64'($urandom_range(1, 4095)));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Reset registers: coefficients zero give a zero divisor below the midline.
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd239);
      send_pixel(12'd100, 12'd240);
      send_pixel(12'd4095, 12'd4095);
      drain();
      write_csr(REG_P0_P2, {32'h00020000, 32'h00010000});
      write_csr(REG_P3_P4, {32'h00008000, 32'h00030000});
      write_csr(REG_P6_P7, {32'h00050000, 32'hfffe0000});
      write_csr(REG_P8_P10, {32'h00000100, 32'h00000200});
      write_csr(REG_P11_R0, {32'h00010000, 32'h00000400});
      write_csr(REG_R2_R3, {32'h00010000, 32'h00000000});
      write_csr(REG_ROWS, 64'd0);
      write_csr(REG_MAXD, 64'h7fffffff);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd256, 12'd512);
      send_pixel(12'd2730, 12'd1365);
      drain();
      write_csr(REG_MAXD, 64'd0);
      write_csr(REG_ROWS, 64'd4095);
      send_pixel(12'd10, 12'd2046);
      send_pixel(12'd10, 12'd2047);
      send_pixel(12'd3000, 12'd4000);
      drain();
      write_csr(REG_P0_P2, {32'h7fffffff, 32'h80000000});
      write_csr(REG_P8_P10, {32'h80000000, 32'h7fffffff});
      write_csr(REG_MAXD, 64'h7fffffff);
      write_csr(REG_ROWS, 64'd1);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd1, 12'd1);
      send_pixel(12'd0, 12'd0);
      drain();
      for (int ph = 0; ph < 12; ph++) begin
         load_camera(ph % 4 == 3);
         if (ph == 10) calm = 1;
         for (int i = 0; i < 150; i++) begin
            if ($urandom_range(0, 3) == 0)
               send_pixel(12'($urandom), 12'($urandom));
            else
               send_pixel(12'($urandom_range(0, 1023)), 12'($urandom_range(0, 1023)));
         end
         drain();
      end
      if (board.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
